[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSA_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CSA_ASSERT(label, clk, rst_n, prop, msg)
`define CSA_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[hw/rtl/csa_pkg.sv]
package csa_pkg;
    localparam int SAMPLE_BITS  = 12;
    localparam int PART_BITS    = SAMPLE_BITS + 1;
    localparam int SPAN_BITS    = 2 * PART_BITS;
    localparam logic signed [11:0] MAP_FS = 12'sd2000;
    // divider lanes
    localparam int Q_BITS       = 24;
    localparam int QUOT_W       = Q_BITS + 1;
    localparam int DIV_NUM_W    = 43;
    localparam int DIV_DEN_W    = 27;
    localparam int DIV_WW       = DIV_DEN_W + Q_BITS;
    localparam int DIV_LAT      = Q_BITS + 1;
    // cordic
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int CW           = 34;
    localparam int ZW           = 35;
    localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;
    localparam logic [31:0] ATAN_Q30 [24] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
    };

    typedef enum logic [2:0] {
        REG_SIN_A_SPAN  = 3'd0,
        REG_SIN_B_SPAN  = 3'd1,
        REG_COS_A_SPAN  = 3'd2,
        REG_COS_B_SPAN  = 3'd3,
        REG_SIN_GAIN    = 3'd4,
        REG_SIN_OFFSET  = 3'd5,
        REG_COS_GAIN    = 3'd6,
        REG_COS_OFFSET  = 3'd7
    } t_reg_idx;

    localparam logic [1:0] FAULT_OK   = 2'd0;
    localparam logic [1:0] FAULT_SPAN = 2'd1;
    localparam logic [1:0] FAULT_SUM  = 2'd2;
endpackage

[hw/rtl/csa_div.sv]
// Pipelined signed divider lane, one quotient bit per stage, truncates toward zero.
// Quotients at or above 2^Q_BITS come out as the largest magnitude.
module csa_div import csa_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [DIV_NUM_W-1:0] i_num,
    input  logic signed [DIV_DEN_W-1:0] i_den,
    output logic                        o_valid,
    output logic signed [QUOT_W-1:0]    o_quot
);
    logic                 r_vld [0:Q_BITS];
    logic                 r_neg [0:Q_BITS];
    logic                 r_ovf [0:Q_BITS];
    logic [Q_BITS-1:0]    r_q   [0:Q_BITS];
    logic [DIV_NUM_W-1:0] r_rem [0:Q_BITS-1];
    logic [DIV_DEN_W-1:0] r_den [0:Q_BITS-1];

    logic [DIV_NUM_W-1:0] num_mag;
    logic [DIV_DEN_W-1:0] den_mag;
    logic [Q_BITS-1:0]    mag;

    assign num_mag = i_num[DIV_NUM_W-1] ? DIV_NUM_W'(-i_num) : DIV_NUM_W'(i_num);
    assign den_mag = i_den[DIV_DEN_W-1] ? DIV_DEN_W'(-i_den) : DIV_DEN_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0] <= num_mag;
        r_den[0] <= den_mag;
        r_q[0]   <= '0;
        r_neg[0] <= i_num[DIV_NUM_W-1] ^ i_den[DIV_DEN_W-1];
        r_ovf[0] <= DIV_WW'(num_mag) >= (DIV_WW'(den_mag) << Q_BITS);
    end

    for (genvar j = 0; j < Q_BITS; j++) begin : g_stage
        localparam int K = Q_BITS - 1 - j;
        logic [DIV_WW-1:0] trial;
        logic [DIV_WW-1:0] diff;
        logic              ge;
        logic [Q_BITS-1:0] n_q;

        assign trial = DIV_WW'(r_den[j]) << K;
        assign ge    = DIV_WW'(r_rem[j]) >= trial;
        assign diff  = DIV_WW'(r_rem[j]) - trial;
        always_comb begin
            n_q    = r_q[j];
            n_q[K] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else begin
                r_vld[j+1] <= r_vld[j];
            end
            r_q[j+1]   <= n_q;
            r_neg[j+1] <= r_neg[j];
            r_ovf[j+1] <= r_ovf[j];
        end

        if (j < Q_BITS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[j+1] <= ge ? diff[DIV_NUM_W-1:0] : r_rem[j];
                r_den[j+1] <= r_den[j];
            end
        end
    end

    assign mag     = r_ovf[Q_BITS] ? '1 : r_q[Q_BITS];
    assign o_valid = r_vld[Q_BITS];
    assign o_quot  = r_neg[Q_BITS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
endmodule

[hw/rtl/csa_cordic.sv]
// Vectoring CORDIC atan2, one rotation per stage; carries the ratios alongside.
module csa_cordic import csa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_sin,
    input  logic signed [15:0] i_cos,
    output logic               o_valid,
    output logic signed [15:0] o_angle,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);
    logic                 r_vld  [0:CORDIC_STEPS];
    logic                 r_zero [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_x    [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_y    [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_z    [0:CORDIC_STEPS];
    logic signed [15:0]   r_s    [0:CORDIC_STEPS];
    logic signed [15:0]   r_c    [0:CORDIC_STEPS];

    logic signed [CW-1:0] x0, y0;
    logic signed [ZW:0]   z_rnd;
    logic signed [ZW-17:0] z_sh;

    logic               r_ovld;
    logic signed [15:0] r_angle, r_os, r_oc;

    assign x0 = CW'(i_cos) <<< 14;
    assign y0 = CW'(i_sin) <<< 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_zero[0] <= (i_cos == 16'sd0) && (i_sin == 16'sd0);
        r_s[0]    <= i_sin;
        r_c[0]    <= i_cos;
        if (i_cos < 16'sd0) begin
            r_x[0] <= -x0;
            r_y[0] <= -y0;
            r_z[0] <= (i_sin >= 16'sd0) ? PI_Q30 : -PI_Q30;
        end else begin
            r_x[0] <= x0;
            r_y[0] <= y0;
            r_z[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] at;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        assign at = $signed(ZW'(ATAN_Q30[i]));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            r_zero[i+1] <= r_zero[i];
            r_s[i+1]    <= r_s[i];
            r_c[i+1]    <= r_c[i];
            if (r_y[i] > 0) begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + at;
            end else begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - at;
            end
        end
    end

    // round half up to Q3.13 and clamp
    assign z_rnd = (ZW+1)'(r_z[CORDIC_STEPS]) + (ZW+1)'(65536);
    assign z_sh  = (ZW-16)'(z_rnd >>> 17);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[CORDIC_STEPS];
        end
        r_os <= r_s[CORDIC_STEPS];
        r_oc <= r_c[CORDIC_STEPS];
        if (r_zero[CORDIC_STEPS]) begin
            r_angle <= '0;
        end else if (z_sh > (ZW-16)'(ANGLE_LIMIT)) begin
            r_angle <= ANGLE_LIMIT;
        end else if (z_sh < -(ZW-16)'(ANGLE_LIMIT)) begin
            r_angle <= -ANGLE_LIMIT;
        end else begin
            r_angle <= 16'(z_sh);
        end
    end

    assign o_valid = r_ovld;
    assign o_angle = r_angle;
    assign o_sin   = r_os;
    assign o_cos   = r_oc;
endmodule

[hw/rtl/capacitive_sincos_angle.sv]
// Throughput: one item per cycle; busy never rises, every stage is a pipeline
// register (two 25-stage divider passes and an 18-stage CORDIC set the depth).
// Reset (synchronous, active low) drops every item in flight and returns the
// registers to max 4096 / min 0 spans, unity gains and zero offsets.
`include "assert_macros.svh"
module capacitive_sincos_angle import csa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command channel
    input  logic                   start,
    output logic                   busy,
    input  logic [SAMPLE_BITS-1:0] i_sin_a_sample,
    input  logic [SAMPLE_BITS-1:0] i_sin_b_sample,
    input  logic [SAMPLE_BITS-1:0] i_cos_a_sample,
    input  logic [SAMPLE_BITS-1:0] i_cos_b_sample,
    // result strobe
    output logic                   o_done,
    output logic signed [15:0]     o_angle,
    output logic signed [15:0]     o_sin_ratio,
    output logic signed [15:0]     o_cos_ratio,
    output logic [1:0]             o_fault,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    localparam int ZS_DEPTH  = DIV_LAT + 1 + CORDIC_LAT + 1;
    localparam int TOTAL_LAT = 2 * DIV_LAT + CORDIC_LAT + 4;

    // ---------------- configuration registers ----------------
    logic [SPAN_BITS-1:0] r_span [4];
    logic signed [15:0]   r_sin_gain, r_sin_off, r_cos_gain, r_cos_off;
    logic                 wr_en;
    t_reg_idx             wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_span[i] <= SPAN_BITS'(4096);
            end
            r_sin_gain <= 16'sd4096;
            r_sin_off  <= '0;
            r_cos_gain <= 16'sd4096;
            r_cos_off  <= '0;
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_SIN_A_SPAN: r_span[0] <= pwdata[SPAN_BITS-1:0];
                REG_SIN_B_SPAN: r_span[1] <= pwdata[SPAN_BITS-1:0];
                REG_COS_A_SPAN: r_span[2] <= pwdata[SPAN_BITS-1:0];
                REG_COS_B_SPAN: r_span[3] <= pwdata[SPAN_BITS-1:0];
                REG_SIN_GAIN:   r_sin_gain <= pwdata[15:0];
                REG_SIN_OFFSET: r_sin_off  <= pwdata[15:0];
                REG_COS_GAIN:   r_cos_gain <= pwdata[15:0];
                REG_COS_OFFSET: r_cos_off  <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            REG_SIN_A_SPAN: prdata = 32'(r_span[0]);
            REG_SIN_B_SPAN: prdata = 32'(r_span[1]);
            REG_COS_A_SPAN: prdata = 32'(r_span[2]);
            REG_COS_B_SPAN: prdata = 32'(r_span[3]);
            REG_SIN_GAIN:   prdata = {16'b0, r_sin_gain};
            REG_SIN_OFFSET: prdata = {16'b0, r_sin_off};
            REG_COS_GAIN:   prdata = {16'b0, r_cos_gain};
            REG_COS_OFFSET: prdata = {16'b0, r_cos_off};
        endcase
    end

    // The user must change registers only while nothing is in flight; the block does not
    // enforce this. Later stages read them directly instead of carrying a copy down the pipe.
    logic span_fault;
    always_comb begin
        span_fault = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (r_span[i][PART_BITS-1:0] == r_span[i][SPAN_BITS-1:PART_BITS]) begin
                span_fault = 1'b1;
            end
        end
    end

    // ---------------- capture register ----------------
    // Every item is taken the cycle it is offered.
    assign busy = 1'b0;

    logic                   r_cap_vld;
    logic [SAMPLE_BITS-1:0] r_cap [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_vld <= 1'b0;
        end else begin
            r_cap_vld <= start && !busy;
        end
        r_cap[0] <= i_sin_a_sample;
        r_cap[1] <= i_sin_b_sample;
        r_cap[2] <= i_cos_a_sample;
        r_cap[3] <= i_cos_b_sample;
    end

    // ---------------- mapping lanes: (x - min) * 2000 / (max - min) ----------------
    logic                     map_vld;
    logic signed [QUOT_W-1:0] mapped [4];

    for (genvar l = 0; l < 4; l++) begin : g_map
        logic signed [PART_BITS:0] diff;
        logic signed [PART_BITS:0] span_w;
        logic signed [25:0]        prod;
        logic                      lane_vld;

        assign diff   = $signed({2'b0, r_cap[l]})
                      - $signed({1'b0, r_span[l][SPAN_BITS-1:PART_BITS]});
        assign span_w = $signed({1'b0, r_span[l][PART_BITS-1:0]})
                      - $signed({1'b0, r_span[l][SPAN_BITS-1:PART_BITS]});
        assign prod   = 26'(diff) * 26'(MAP_FS);

        csa_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_cap_vld),
            .i_num   (DIV_NUM_W'(prod)),
            .i_den   (DIV_DEN_W'(span_w)),
            .o_valid (lane_vld),
            .o_quot  (mapped[l])
        );

        if (l == 0) begin : g_vld
            assign map_vld = lane_vld;
        end
    end

    // ---------------- merge: pair difference times gain over pair sum ----------------
    logic                       r_rp_vld;
    logic signed [DIV_NUM_W-1:0] r_s_num, r_c_num;
    logic signed [DIV_DEN_W-1:0] r_s_den, r_c_den;
    logic signed [QUOT_W:0]     s_dif, s_sum, c_dif, c_sum;
    logic signed [QUOT_W+16:0]  s_prod, c_prod;

    assign s_dif  = (QUOT_W+1)'(mapped[0]) - (QUOT_W+1)'(mapped[1]);
    assign s_sum  = (QUOT_W+1)'(mapped[0]) + (QUOT_W+1)'(mapped[1]);
    assign c_dif  = (QUOT_W+1)'(mapped[2]) - (QUOT_W+1)'(mapped[3]);
    assign c_sum  = (QUOT_W+1)'(mapped[2]) + (QUOT_W+1)'(mapped[3]);
    assign s_prod = (QUOT_W+17)'(s_dif) * (QUOT_W+17)'(r_sin_gain);
    assign c_prod = (QUOT_W+17)'(c_dif) * (QUOT_W+17)'(r_cos_gain);

    logic r_zs [ZS_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp_vld <= 1'b0;
        end else begin
            r_rp_vld <= map_vld;
        end
        r_s_num <= DIV_NUM_W'(s_prod);
        r_c_num <= DIV_NUM_W'(c_prod);
        r_s_den <= DIV_DEN_W'(s_sum);
        r_c_den <= DIV_DEN_W'(c_sum);
        // flag a zero pair sum and walk it alongside the item
        r_zs[0] <= (s_sum == '0) || (c_sum == '0);
        for (int i = 1; i < ZS_DEPTH; i++) begin
            r_zs[i] <= r_zs[i-1];
        end
    end

    logic                     rd_vld;
    logic signed [QUOT_W-1:0] s_q, c_q;

    csa_div u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rp_vld),
        .i_num   (r_s_num),
        .i_den   (r_s_den),
        .o_valid (rd_vld),
        .o_quot  (s_q)
    );

    csa_div u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rp_vld),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .o_valid (),
        .o_quot  (c_q)
    );

    // ---------------- add offset and saturate ----------------
    logic signed [QUOT_W:0] s_off, c_off;
    logic                   r_sat_vld;
    logic signed [15:0]     r_sin, r_cos;

    assign s_off = (QUOT_W+1)'(s_q) + (QUOT_W+1)'(r_sin_off);
    assign c_off = (QUOT_W+1)'(c_q) + (QUOT_W+1)'(r_cos_off);

    function automatic logic signed [15:0] f_sat16(input logic signed [QUOT_W:0] v);
        if (v > (QUOT_W+1)'(16'sh7fff)) begin
            return 16'sh7fff;
        end else if (v < (QUOT_W+1)'(-17'sd32768)) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_vld <= 1'b0;
        end else begin
            r_sat_vld <= rd_vld;
        end
        r_sin <= f_sat16(s_off);
        r_cos <= f_sat16(c_off);
    end

    // ---------------- angle ----------------
    logic               cd_vld;
    logic signed [15:0] cd_angle, cd_sin, cd_cos;

    csa_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_sat_vld),
        .i_sin   (r_sin),
        .i_cos   (r_cos),
        .o_valid (cd_vld),
        .o_angle (cd_angle),
        .o_sin   (cd_sin),
        .o_cos   (cd_cos)
    );

    // ---------------- result register ----------------
    // Span fault wins over a zero pair sum; either one zeroes the numbers.
    logic               r_done;
    logic signed [15:0] r_angle, r_sr, r_cr;
    logic [1:0]         r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= cd_vld;
        end
        priority if (span_fault) begin
            r_fault <= FAULT_SPAN;
            r_angle <= '0;
            r_sr    <= '0;
            r_cr    <= '0;
        end else if (r_zs[ZS_DEPTH-1]) begin
            r_fault <= FAULT_SUM;
            r_angle <= '0;
            r_sr    <= '0;
            r_cr    <= '0;
        end else begin
            r_fault <= FAULT_OK;
            r_angle <= cd_angle;
            r_sr    <= cd_sin;
            r_cr    <= cd_cos;
        end
    end

    assign o_done      = r_done;
    assign o_angle     = r_angle;
    assign o_sin_ratio = r_sr;
    assign o_cos_ratio = r_cr;
    assign o_fault     = r_fault;

    // ---------------- checks ----------------
    `CSA_ASSERT(a_done_follows_item, i_clk, i_rst_n, o_done |-> $past(start && !busy, TOTAL_LAT), "result without matching item")
    `CSA_NEVER(a_angle_range, i_clk, i_rst_n, o_done && (o_angle > ANGLE_LIMIT || o_angle < -ANGLE_LIMIT), "angle out of range")
    `CSA_NEVER(a_fault_zeroes, i_clk, i_rst_n, o_done && o_fault != FAULT_OK && o_angle != 16'sd0, "faulted item carries an angle")
endmodule
